// ===== rtl/b64d_pkg.sv =====
`default_nettype none
package b64d_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_OK   = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // sextet codes beyond the 6-bit alphabet
  localparam logic [6:0] SEXTET_PAD = 7'd64;
  localparam logic [6:0] SEXTET_BAD = 7'd65;

  // ascii codes of the alphabet bounds
  localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CH_UZ    = 8'h5a;  // 'Z'
  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CH_LZ    = 8'h7a;  // 'z'
  localparam logic [7:0] CH_D0    = 8'h30;  // '0'
  localparam logic [7:0] CH_D9    = 8'h39;  // '9'
  localparam logic [7:0] CH_PLUS  = 8'h2b;  // '+'
  localparam logic [7:0] CH_SLASH = 8'h2f;  // '/'
  localparam logic [7:0] CH_EQ    = 8'h3d;  // '='

  // request queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // one queued request: decoded bytes of a quartet and an optional status
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    logic            status;
    logic            status_err;
  } job_t;

  // queue status seen by the input stall and the back stage
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // map one character to its sextet, pad or bad code
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    d = {1'b0, SEXTET_BAD};
    if (c >= CH_UA && c <= CH_UZ) begin
      d = c - CH_UA;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = c - (CH_LA - 8'd26);
    end else if (c >= CH_D0 && c <= CH_D9) begin
      d = c + (8'd52 - CH_D0);
    end else if (c == CH_PLUS) begin
      d = 8'd62;
    end else if (c == CH_SLASH) begin
      d = 8'd63;
    end else if (c == CH_EQ) begin
      d = {1'b0, SEXTET_PAD};
    end
    return d[6:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/b64d_front.sv =====
`default_nettype none
module b64d_front
  import b64d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] char_code,
  input  wire logic       end_of_text,
  output logic            push,
  output job_t            job
);

  logic [1:0]  pos_r, pos_nxt;
  logic [17:0] held_r, held_nxt;
  logic        pad3_r, pad3_nxt;
  logic        failed_r, failed_nxt;

  // classify the character, update quartet state and build the request
  always_comb begin
    logic [6:0] v;
    logic [5:0] s0, s1, s2;
    logic       is_pad;
    v      = sextet_of(char_code);
    is_pad = (v == SEXTET_PAD);
    s0     = held_r[17:12];
    s1     = held_r[11:6];
    s2     = held_r[5:0];

    pos_nxt    = pos_r;
    held_nxt   = held_r;
    pad3_nxt   = pad3_r;
    failed_nxt = failed_r;

    job.bytes[0]   = {s0, s1[5:4]};
    job.bytes[1]   = {s1[3:0], s2[5:2]};
    job.bytes[2]   = {s2[1:0], v[5:0]};
    job.nbytes     = 2'd0;
    job.status     = end_of_text;
    job.status_err = 1'b0;

    if (!failed_r) begin
      if (v == SEXTET_BAD || (is_pad && pos_r <= 2'd1)) begin
        failed_nxt = 1'b1;
      end else begin
        case (pos_r)
          2'd0: begin
            held_nxt = {v[5:0], 12'd0};
            pad3_nxt = 1'b0;
            pos_nxt  = 2'd1;
          end
          2'd1: begin
            held_nxt = {held_r[17:12], v[5:0], 6'd0};
            pos_nxt  = 2'd2;
          end
          2'd2: begin
            if (is_pad) begin
              pad3_nxt = 1'b1;
            end else begin
              held_nxt = {held_r[17:6], v[5:0]};
            end
            pos_nxt = 2'd3;
          end
          default: begin
            if (pad3_r) begin
              job.nbytes = 2'd1;
            end else if (is_pad) begin
              job.nbytes = 2'd2;
            end else begin
              job.nbytes = 2'd3;
            end
            pos_nxt = 2'd0;
          end
        endcase
      end
    end

    job.status_err = failed_nxt || (pos_nxt != 2'd0);
    push           = accept && (job.nbytes != 2'd0 || end_of_text);

    // end of text returns to the idle quartet state
    if (end_of_text) begin
      pos_nxt    = 2'd0;
      held_nxt   = 18'd0;
      pad3_nxt   = 1'b0;
      failed_nxt = 1'b0;
    end
  end

  // quartet state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 2'd0;
      held_r   <= 18'd0;
      pad3_r   <= 1'b0;
      failed_r <= 1'b0;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      held_r   <= held_nxt;
      pad3_r   <= pad3_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/b64d_queue.sv =====
`default_nettype none
module b64d_queue
  import b64d_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  job_t      wr_job,
  input  wire logic pop,
  output job_t      rd_job,
  output qstat_t    stat
);

  job_t           mem [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;

  assign stat.full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rd_job     = mem[rp_r];

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wr_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/b64d_back.sv =====
`default_nettype none
module b64d_back
  import b64d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  job_t            head,
  input  qstat_t          qstat,
  output logic            pop,
  input  wire logic       out_stall,
  output logic            out_valid,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_kind,
  output logic            out_last
);

  job_t       job_r;
  logic       busy_r;
  logic [1:0] idx_r, idx_nxt;
  logic       final_res, fire, load;

  // pick the current result of the held request
  always_comb begin
    logic [2:0] total;
    total     = {1'b0, job_r.nbytes} + {2'b0, job_r.status};
    final_res = ({1'b0, idx_r} == total - 3'd1);
    if (idx_r < job_r.nbytes) begin
      case (idx_r)
        2'd0:    out_byte = job_r.bytes[0];
        2'd1:    out_byte = job_r.bytes[1];
        default: out_byte = job_r.bytes[2];
      endcase
      out_kind = KIND_DATA;
      out_last = final_res;
    end else begin
      out_byte = 8'd0;
      out_kind = job_r.status_err ? KIND_ERR : KIND_OK;
      out_last = 1'b1;
    end
  end

  // hand-off: take the next request when idle or on the final result
  assign out_valid = busy_r;
  assign fire      = busy_r && !out_stall;
  assign load      = !busy_r || (fire && final_res);
  assign pop       = load && !qstat.empty;
  assign idx_nxt   = load ? 2'd0 : (fire ? idx_r + 2'd1 : idx_r);

  // request register and result index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      if (load) begin
        busy_r <= !qstat.empty;
      end
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= head;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/base64_decoder_top.sv =====
`default_nettype none
// Streaming Base64 decoder, RFC 4648 alphabet, one text character per
// request on the input channel. A front stage classifies each character
// and tracks the quartet; completed quartets (and the end-of-text status)
// go into a four-entry request queue; a back stage sends them out as one
// result per cycle while out_stall is low (data bytes, then a status on
// the end-of-text character, with out_last on the final result of each
// character). The input takes one character per cycle while the queue has
// room; a quartet takes four characters and gives up to four results. With
// the back stage idle, a character's request is written into the queue and
// then loaded into the back stage's request register before its first
// result is presented. After an error the rest of the text is dropped and
// only the error status is reported at its end.
module base64_decoder_top
  import b64d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_code,
  input  wire logic       in_end_of_text,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_kind,
  output logic            out_last
);

  logic   accept, push, pop;
  job_t   wr_job, rd_job;
  qstat_t qstat;

  assign in_stall = qstat.full;
  assign accept   = in_valid && !in_stall;

  b64d_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .char_code   (in_char_code),
    .end_of_text (in_end_of_text),
    .push        (push),
    .job         (wr_job)
  );

  b64d_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .stat   (qstat)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (rd_job),
    .qstat     (qstat),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .out_kind  (out_kind),
    .out_last  (out_last)
  );

  // queue cannot be full and empty at once
  a_qstat: assert property (@(posedge clk) disable iff (!rst_n)
    !(qstat.full && qstat.empty))
    else $error("queue full and empty together");

  // a status result is always the last of its character
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_DATA) |-> (out_last && out_byte == 8'd0))
    else $error("status result not final or nonzero byte");

  // never pop an empty queue
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== tb/tb_base64_decoder_top.sv =====
`default_nettype none
module tb_base64_decoder_top
  import b64d_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_CHARS  = 80;
  localparam int DRAIN_CYCLES  = 12;
  localparam int PAD_VALUE     = 64;
  localparam int BAD_VALUE     = -1;

  // predicted decoder results, checked in arrival order
  class decoded_text_scoreboard;
    typedef struct packed {
      logic [7:0] data;
      kind_t      kind;
      logic       last;
    } decode_result_t;

    decode_result_t awaited_results[$];
    logic [1:0]  slot;
    logic [17:0] sextets;
    logic        third_pad;
    logic        text_failed;
    int          mismatches;
    int          live_chars;

    function new();
      mismatches = 0;
      live_chars = 0;
      clear_text();
    endfunction

    function void clear_text();
      slot        = 2'd0;
      sextets     = 18'd0;
      third_pad   = 1'b0;
      text_failed = 1'b0;
    endfunction

    // alphabet value of a character, pad or bad
    function int char_value(logic [7:0] c);
      int ci;
      ci = c;
      if (ci >= "A" && ci <= "Z") return ci - "A";
      if (ci >= "a" && ci <= "z") return ci - "a" + 26;
      if (ci >= "0" && ci <= "9") return ci - "0" + 52;
      if (ci == "+") return 62;
      if (ci == "/") return 63;
      if (ci == "=") return PAD_VALUE;
      return BAD_VALUE;
    endfunction

    // work out the results caused by one accepted request
    function void take_char(logic [7:0] c, logic eot);
      decode_result_t fresh [4];
      int n;
      int v;
      logic [5:0] s0;
      logic [5:0] s1;
      logic [5:0] s2;
      n = 0;
      if (!text_failed) begin
        live_chars++;
        v  = char_value(c);
        s0 = sextets[17:12];
        s1 = sextets[11:6];
        s2 = sextets[5:0];
        if (v == BAD_VALUE || (v == PAD_VALUE && slot <= 2'd1)) begin
          text_failed = 1'b1;
        end else begin
          case (slot)
            2'd0: begin
              sextets   = {v[5:0], 12'd0};
              third_pad = 1'b0;
              slot      = 2'd1;
            end
            2'd1: begin
              sextets[11:6] = v[5:0];
              slot          = 2'd2;
            end
            2'd2: begin
              if (v == PAD_VALUE) third_pad = 1'b1;
              else sextets[5:0] = v[5:0];
              slot = 2'd3;
            end
            default: begin
              fresh[n] = '{data: {s0, s1[5:4]}, kind: KIND_DATA, last: 1'b0};
              n++;
              if (!third_pad) begin
                fresh[n] = '{data: {s1[3:0], s2[5:2]}, kind: KIND_DATA, last: 1'b0};
                n++;
                if (v != PAD_VALUE) begin
                  fresh[n] = '{data: {s2[1:0], v[5:0]}, kind: KIND_DATA, last: 1'b0};
                  n++;
                end
              end
              slot = 2'd0;
            end
          endcase
        end
      end
      // end of text: status, then back to a fresh text
      if (eot) begin
        fresh[n] = '{data: 8'd0,
                     kind: (text_failed || slot != 2'd0) ? KIND_ERR : KIND_OK,
                     last: 1'b0};
        n++;
        clear_text();
      end
      if (n > 0) fresh[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) awaited_results.push_back(fresh[i]);
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_output(logic [7:0] data, logic [1:0] kind, logic last);
      decode_result_t want;
      if (awaited_results.size() == 0) begin
        $error("unexpected result: out_byte %0h out_kind %0d out_last %0b",
               data, kind, last);
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      if (data !== want.data) begin
        $error("out_byte: expected %0h, actual %0h", want.data, data);
        mismatches++;
      end
      if (kind !== want.kind) begin
        $error("out_kind: expected %0d, actual %0d", want.kind, kind);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("out_last: expected %0b, actual %0b", want.last, last);
        mismatches++;
      end
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction
  endclass

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char_code;
  logic       in_end_of_text;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       out_last;

  decoded_text_scoreboard sb;
  logic [7:0]  text_chars[$];
  int          burst_left = 4;
  int          cycle_count = 0;
  int          stall_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  base64_decoder_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_code   (in_char_code),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_kind       (out_kind),
    .out_last       (out_last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver stall pattern, switching style every so often
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(32, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_left[1:0] != 2'd0);
    endcase
  end

  // observe both channels in one process, requests first
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.take_char(in_char_code, in_end_of_text);
      if (out_valid && !out_stall) sb.check_output(out_byte, out_kind, out_last);
    end
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** base64_decoder_top: FAILED **");
      $finish;
    end
  end

  // offer one character and wait until it is taken
  task automatic send_char(input logic [7:0] c, input logic eot);
    in_valid       <= 1'b1;
    in_char_code   <= c;
    in_end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold off until every predicted result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // send the built text, the final character flagged as end of text
  task automatic send_text(input bit steady);
    for (int i = 0; i < text_chars.size(); i++) begin
      send_char(text_chars[i], i == text_chars.size() - 1);
      if (!steady) begin
        burst_left--;
        if (burst_left <= 0) begin
          pause_sender($urandom_range(1, 6));
          burst_left = $urandom_range(1, 12);
        end
      end
    end
    text_chars.delete();
  endtask

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) text_chars.push_back(s[i]);
  endfunction

  function automatic logic [7:0] alphabet_char();
    int r;
    r = $urandom_range(0, 63);
    if (r < 26) return 8'("A" + r);
    if (r < 52) return 8'("a" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    if (r == 62) return 8'("+");
    return 8'("/");
  endfunction

  // random text: mostly well-formed quartets, some broken or pure noise
  function automatic void build_random_text();
    int quartets;
    int pads;
    int idx;
    quartets = $urandom_range(1, 4);
    for (int q = 0; q < quartets; q++) begin
      pads = 0;
      if (q == quartets - 1 || $urandom_range(0, 5) == 0) pads = $urandom_range(0, 2);
      text_chars.push_back(alphabet_char());
      text_chars.push_back(alphabet_char());
      if (pads == 2) begin
        text_chars.push_back("=");
        text_chars.push_back(($urandom_range(0, 3) == 0) ? alphabet_char() : 8'("="));
      end else if (pads == 1) begin
        text_chars.push_back(alphabet_char());
        text_chars.push_back("=");
      end else begin
        text_chars.push_back(alphabet_char());
        text_chars.push_back(alphabet_char());
      end
    end
    if ($urandom_range(0, 9) < 3) begin
      idx = $urandom_range(0, text_chars.size() - 1);
      case ($urandom_range(0, 4))
        0: text_chars[idx] = 8'($urandom_range(0, 255));
        1: text_chars[idx] = "=";
        2: begin
          // cut the text short
          repeat ($urandom_range(1, 3)) begin
            if (text_chars.size() > 1) void'(text_chars.pop_back());
          end
        end
        3: text_chars.push_back(8'($urandom_range(0, 255)));
        default: begin
          // pure noise
          text_chars.delete();
          repeat ($urandom_range(1, 6)) text_chars.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
  endfunction

  // stimulus
  initial begin
    int texts_sent;
    int live_start;
    sb             = new();
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_char_code   <= 8'd0;
    in_end_of_text <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // alphabet extremes, full quartets, status after three bytes
    add_text("Az+/Za09");
    send_text(1'b1);
    // third pad with a valid fourth, then more data after a padded quartet
    add_text("QQ=AQUI=");
    send_text(1'b0);
    // pad at quartet start on the end character
    add_text("=");
    send_text(1'b0);
    // pad in second place
    add_text("Q=");
    send_text(1'b0);
    // invalid byte on the end character
    text_chars.push_back(8'h00);
    send_text(1'b0);
    // high byte mid text, the rest ignored
    text_chars.push_back("A");
    text_chars.push_back(8'hff);
    text_chars.push_back("B");
    send_text(1'b0);
    // text ending partway through a quartet
    add_text("QUJ");
    send_text(1'b0);
    wait_for_results();
    pause_sender($urandom_range(1, 10));

    // random texts
    texts_sent = 0;
    live_start = sb.live_chars;
    while (sb.live_chars - live_start < RANDOM_CHARS) begin
      build_random_text();
      send_text($urandom_range(0, 4) == 0);
      texts_sent++;
      if (texts_sent % 5 == 0) begin
        wait_for_results();
        pause_sender($urandom_range(1, 8));
      end
    end

    // drain
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("** base64_decoder_top: PASSED **");
    end else begin
      $display("** base64_decoder_top: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
